@@ src/ptt_pkg.sv @@
package ptt_pkg;

    // Field widths
    localparam int ID_W     = 16;
    localparam int PER_W    = 16;
    localparam int TIME_W   = 32;
    localparam int INC_W    = 20;
    localparam int ENTRY_W  = ID_W + 2 * TIME_W;

    // Register file
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam logic [INC_W-1:0] INC_RESET = 20'd1000;

    // Period scale
    localparam logic [9:0] US_PER_MS = 10'd1000;

    // Command codes
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_SERVICE = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_NONE   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

@@ src/ptt_ram.sv @@
module ptt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/periodic_task_timer_table.sv @@
// Periodic task timer table.
// Input channel (i_valid / o_stall) takes one command transaction: add task,
// remove task, timer tick or service pass. Output channel (o_valid / i_stall)
// returns result transactions; o_last marks the final result of a command.
// The APB port holds tick_increment_us at address 0 (pready always high).
// A tick gives no result. After the accept state, an add or remove over N
// entries passes a read and a check state per entry searched, a decision
// state and a state that loads the result; a remove passes a read and a
// write state per later entry moved up in place of the entries it no
// longer searches. A charging service pass takes the accept state, a read
// and a check state per entry and a closing state; a repeated service goes
// straight to the closing state. Entries are visited one at a time: the
// table memory has one registered read port, and one accumulate-and-compare
// unit is shared by all. o_stall is high while a command is in progress.
// A result waits in the output register while the receiver stalls; a service
// pass pauses on the next fired task until that register is free, and a new
// command is taken even while the last result still waits.
// Synchronous reset empties the table, clears the time counters and loads
// the tick increment with 1000 us.
module periodic_task_timer_table #(
    parameter int MAX_TASKS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_command,
    input  logic [ptt_pkg::ID_W-1:0]      i_task_id,
    input  logic [ptt_pkg::PER_W-1:0]     i_period_ms,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_kind,
    output logic [ptt_pkg::ID_W-1:0]      o_fired_id,
    output logic [1:0]                    o_status,
    output logic                          o_last,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptt_pkg::APB_AW-1:0]    paddr,
    input  logic [ptt_pkg::APB_DW-1:0]    pwdata,
    output logic [ptt_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = ptt_pkg::TIME_W;
    localparam int DW = ptt_pkg::ID_W;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_FIND_RD  = 10'b0000000010,
        S_FIND_CHK = 10'b0000000100,
        S_DECIDE   = 10'b0000001000,
        S_RM_RD    = 10'b0000010000,
        S_RM_WR    = 10'b0000100000,
        S_SV_RD    = 10'b0001000000,
        S_SV_CHK   = 10'b0010000000,
        S_SV_END   = 10'b0100000000,
        S_EMIT     = 10'b1000000000
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0]                 r_cmd, n_cmd;
    logic [DW-1:0]              r_id, n_id;
    logic [TW-1:0]              r_per_us, n_per_us;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_found, n_found;
    logic [1:0]                 r_status, n_status;
    logic [TW-1:0]              r_time_now, n_time_now;
    logic [TW-1:0]              r_time_last, n_time_last;
    logic                       r_serviced, n_serviced;
    logic [TW-1:0]              r_passed, n_passed;
    logic                       r_pend_valid, n_pend_valid;
    logic [DW-1:0]              r_pend_id, n_pend_id;
    logic [ptt_pkg::INC_W-1:0]  r_inc, n_inc;

    logic                       r_out_valid, n_out_valid;
    logic [1:0]                 r_out_kind, n_out_kind;
    logic [DW-1:0]              r_out_id, n_out_id;
    logic [1:0]                 r_out_status, n_out_status;
    logic                       r_out_last, n_out_last;

    // table memory ports
    logic                       w_we;
    logic [IW-1:0]              w_waddr;
    logic [ptt_pkg::ENTRY_W-1:0] w_wdata;
    logic [IW-1:0]              w_raddr;
    logic [ptt_pkg::ENTRY_W-1:0] w_rdata;

    logic [DW-1:0]              w_rd_id;
    logic [TW-1:0]              w_rd_per;
    logic [TW-1:0]              w_rd_elapsed;
    logic [CW-1:0]              w_idx_nxt;
    logic [CW:0]                w_idx_nxt2;
    logic [TW:0]                w_sum;
    logic [TW-1:0]              w_acc;
    logic                       w_fire;
    logic                       w_out_free;
    logic                       w_cfg_we;

    ptt_ram #(
        .WIDTH (ptt_pkg::ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Split the entry read back from the table
    assign w_rd_id      = w_rdata[ptt_pkg::ENTRY_W-1 -: DW];
    assign w_rd_per     = w_rdata[2*TW-1 -: TW];
    assign w_rd_elapsed = w_rdata[TW-1:0];

    assign w_idx_nxt  = r_idx + CW'(1);
    assign w_idx_nxt2 = {1'b0, w_idx_nxt} + (CW+1)'(1);

    // Shared accumulate unit: saturating add, then compare with the period
    assign w_sum  = {1'b0, w_rd_elapsed} + {1'b0, r_passed};
    assign w_acc  = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];
    assign w_fire = (w_acc >= w_rd_per);

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_cfg_we   = psel && penable && pwrite;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_per_us     = r_per_us;
        n_idx        = r_idx;
        n_count      = r_count;
        n_found      = r_found;
        n_status     = r_status;
        n_time_now   = r_time_now;
        n_time_last  = r_time_last;
        n_serviced   = r_serviced;
        n_passed     = r_passed;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_inc        = r_inc;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_we         = 1'b0;
        w_waddr      = r_idx[IW-1:0];
        w_wdata      = w_rdata;
        w_raddr      = r_idx[IW-1:0];

        // drop the result once taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        // configuration write
        if (w_cfg_we && !paddr[2]) begin
            n_inc = pwdata[ptt_pkg::INC_W-1:0];
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_command;
                    n_id     = i_task_id;
                    n_per_us = TW'(i_period_ms) * TW'(ptt_pkg::US_PER_MS);
                    n_idx    = '0;
                    n_found  = 1'b0;
                    case (i_command)
                        ptt_pkg::CMD_ADD, ptt_pkg::CMD_REMOVE: begin
                            n_state = (r_count == '0) ? S_DECIDE : S_FIND_RD;
                        end
                        ptt_pkg::CMD_TICK: begin
                            n_time_now = r_time_now + TW'(r_inc);
                            n_serviced = 1'b0;
                        end
                        default: begin
                            n_passed     = r_time_now - r_time_last;
                            n_time_last  = r_time_now;
                            n_pend_valid = 1'b0;
                            n_serviced   = 1'b1;
                            n_state = (!r_serviced && r_count != '0) ? S_SV_RD : S_SV_END;
                        end
                    endcase
                end
            end
            S_FIND_RD: begin
                n_state = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (w_rd_id == r_id) begin
                    n_found = 1'b1;
                    n_state = S_DECIDE;
                end else if (w_idx_nxt < r_count) begin
                    n_idx   = w_idx_nxt;
                    n_state = S_FIND_RD;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_EMIT;
                if (r_cmd == ptt_pkg::CMD_ADD) begin
                    if (r_found) begin
                        n_status = ptt_pkg::ST_DUPLICATE;
                    end else if (r_count == CW'(MAX_TASKS)) begin
                        n_status = ptt_pkg::ST_FULL;
                    end else begin
                        // append with a cleared accumulator
                        w_we     = 1'b1;
                        w_waddr  = r_count[IW-1:0];
                        w_wdata  = {r_id, r_per_us, {TW{1'b0}}};
                        n_count  = r_count + CW'(1);
                        n_status = ptt_pkg::ST_OK;
                    end
                end else begin
                    if (!r_found) begin
                        n_status = ptt_pkg::ST_NOT_FOUND;
                    end else begin
                        n_status = ptt_pkg::ST_OK;
                        if (w_idx_nxt < r_count) begin
                            n_state = S_RM_RD;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
            end
            S_RM_RD: begin
                w_raddr = w_idx_nxt[IW-1:0];
                n_state = S_RM_WR;
            end
            S_RM_WR: begin
                // move the next entry up one slot
                w_raddr = w_idx_nxt[IW-1:0];
                w_we    = 1'b1;
                w_waddr = r_idx[IW-1:0];
                w_wdata = w_rdata;
                n_idx   = w_idx_nxt;
                if (w_idx_nxt2 < {1'b0, r_count}) begin
                    n_state = S_RM_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_EMIT;
                end
            end
            S_SV_RD: begin
                n_state = S_SV_CHK;
            end
            S_SV_CHK: begin
                // hold while a fired task waits for the output register
                if (!w_fire || !r_pend_valid || w_out_free) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wdata = {w_rd_id, w_rd_per, (w_fire ? {TW{1'b0}} : w_acc)};
                    if (w_fire) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = ptt_pkg::KIND_FIRED;
                            n_out_id     = r_pend_id;
                            n_out_status = ptt_pkg::ST_OK;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_id    = w_rd_id;
                    end
                    if (w_idx_nxt < r_count) begin
                        n_idx   = w_idx_nxt;
                        n_state = S_SV_RD;
                    end else begin
                        n_state = S_SV_END;
                    end
                end
            end
            S_SV_END: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_valid ? ptt_pkg::KIND_FIRED : ptt_pkg::KIND_NONE;
                    n_out_id     = r_pend_valid ? r_pend_id : '0;
                    n_out_status = ptt_pkg::ST_OK;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = ptt_pkg::KIND_STATUS;
                    n_out_id     = r_id;
                    n_out_status = r_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_time_now   <= '0;
            r_time_last  <= '0;
            r_serviced   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_inc        <= ptt_pkg::INC_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_time_now   <= n_time_now;
            r_time_last  <= n_time_last;
            r_serviced   <= n_serviced;
            r_pend_valid <= n_pend_valid;
            r_inc        <= n_inc;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_id         <= n_id;
        r_per_us     <= n_per_us;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_status     <= n_status;
        r_passed     <= n_passed;
        r_pend_id    <= n_pend_id;
        r_out_kind   <= n_out_kind;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_fired_id = r_out_id;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : ptt_pkg::APB_DW'(r_inc);

endmodule

@@ src/ptt_checker.sv @@
module ptt_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      o_valid,
    input  logic                      i_stall,
    input  logic [1:0]                o_kind,
    input  logic [ptt_pkg::ID_W-1:0]  o_fired_id,
    input  logic [1:0]                o_status,
    input  logic                      o_last
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_fired_id)
            && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // Status results and empty services close their command
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == ptt_pkg::KIND_STATUS || o_kind == ptt_pkg::KIND_NONE)
            |-> o_last)
        else $error("single result without last");

    // Service results carry no status and an empty service no id
    a_svc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != ptt_pkg::KIND_STATUS |-> o_status == ptt_pkg::ST_OK
            && (o_kind != ptt_pkg::KIND_NONE || o_fired_id == '0))
        else $error("bad service result fields");

    // Never show an undefined kind
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_kind == ptt_pkg::KIND_STATUS || o_kind == ptt_pkg::KIND_FIRED
            || o_kind == ptt_pkg::KIND_NONE)
        else $error("undefined result kind");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_kind     (o_kind),
    .o_fired_id (o_fired_id),
    .o_status   (o_status),
    .o_last     (o_last)
);
